[rtl/core/rbd_pkg.sv]
package rbd_pkg;

   typedef enum logic [3:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_PUSH_BACK  = 4'd1,
      CMD_POP_FRONT  = 4'd2,
      CMD_POP_BACK   = 4'd3,
      CMD_GET        = 4'd4,
      CMD_SET        = 4'd5,
      CMD_INSERT     = 4'd6,
      CMD_REMOVE     = 4'd7,
      CMD_CLEAR      = 4'd8,
      CMD_RESIZE     = 4'd9,
      CMD_SWAP       = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   localparam int CMD_W = 4;

endpackage

[rtl/core/rbd_ram.sv]
module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ring_buffer_deque.sv]
// Fixed-capacity double-ended queue of DEPTH elements of WIDTH bits, kept in one
// single-port-read, single-port-write RAM addressed through a head slot and a
// length. Every command beat returns exactly one response beat carrying the read
// element (get only, zero otherwise), a status (ok, full, empty, out of range) and
// the length after the command. The command is taken while a previous response
// still waits in the output register. Swap reads both elements and writes them
// back crossed; resize that grows zero-fills each new element; insert and remove
// shift the elements on the side of the nearer end, none when nothing shifts and
// at most about DEPTH/2 otherwise. The element RAM has one read and one write
// port, and a move copies one element per cycle through its registered read. A
// finished command waits in the done state while a full output register is not
// drained, and no new command is taken until it is handed on.
module ring_buffer_deque #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1),
   localparam int IN_DW = ((CW + AW + WIDTH + 7) / 8) * 8,
   localparam int OUT_DW = ((WIDTH + CW + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_DW-1:0]         req_tdata,  // index, second_index, value
   input  logic [rbd_pkg::CMD_W-1:0] req_tuser, // command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_DW-1:0]        rsp_tdata,  // read_value, length
   output logic [1:0]               rsp_tuser   // status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_FILL,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   rbd_pkg::status_type  status_ff, status_in;
   logic                 get_ok_ff, get_ok_in;
   logic                 ins_ff, ins_in;
   logic                 front_ff, front_in;
   logic                 up_ff, up_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [CW-1:0]        left_ff, left_in;
   logic [AW-1:0]        to_ff, to_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        pos_b_ff, pos_b_in;
   logic [AW-1:0]        wr_slot_ff, wr_slot_in;
   logic [WIDTH-1:0]     val_ff, val_in;
   logic [WIDTH-1:0]     tmp_ff, tmp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic [CW-1:0]        rsp_len_ff, rsp_len_in;
   rbd_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WIDTH-1:0]     wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WIDTH-1:0]     ram_rdata;

   logic [rbd_pkg::CMD_W-1:0] req_cmd;
   logic [CW-1:0]        req_idx;
   logic [AW-1:0]        req_jdx;
   logic [WIDTH-1:0]     req_val;
   logic [AW-1:0]        idx_lo;
   logic [AW-1:0]        count_lo;
   logic [CW-1:0]        rem_back;
   logic [AW-1:0]        from_pos;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (AW + 1)'(DEPTH)) begin
         return AW'(sum - (AW + 1)'(DEPTH));
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] head_back(input logic [AW-1:0] head);
      return (head == '0) ? AW'(DEPTH - 1) : AW'(head - 1'b1);
   endfunction

   function automatic logic [AW-1:0] head_fwd(input logic [AW-1:0] head);
      return (head == AW'(DEPTH - 1)) ? '0 : AW'(head + 1'b1);
   endfunction

   assign req_cmd  = req_tuser;
   assign req_idx  = req_tdata[CW-1:0];
   assign req_jdx  = req_tdata[CW +: AW];
   assign req_val  = req_tdata[CW + AW +: WIDTH];
   assign idx_lo   = req_idx[AW-1:0];
   assign count_lo = count_ff[AW-1:0];
   assign rem_back = CW'(count_ff - req_idx - 1'b1);
   assign from_pos = up_ff ? AW'(to_ff + 1'b1) : AW'(to_ff - 1'b1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'({rsp_len_ff, rsp_data_ff});
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      get_ok_in     = get_ok_ff;
      ins_in        = ins_ff;
      front_in      = front_ff;
      up_in         = up_ff;
      wr_pend_in    = wr_pend_ff;
      left_in       = left_ff;
      to_in         = to_ff;
      pos_in        = pos_ff;
      pos_b_in      = pos_b_ff;
      wr_slot_in    = wr_slot_ff;
      val_in        = val_ff;
      tmp_in        = tmp_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in   = S_DONE;
               status_in  = rbd_pkg::ST_OK;
               get_ok_in  = 1'b0;
               ins_in     = 1'b0;
               front_in   = 1'b0;
               wr_pend_in = 1'b0;
               val_in     = req_val;
               pos_in     = idx_lo;
               unique case (req_cmd)
                  rbd_pkg::CMD_PUSH_FRONT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = rbd_pkg::ST_FULL;
                     end else begin
                        head_in  = head_back(head_ff);
                        count_in = CW'(count_ff + 1'b1);
                        wr_en    = 1'b1;
                        wr_addr  = head_back(head_ff);
                        wr_data  = req_val;
                     end
                  end
                  rbd_pkg::CMD_PUSH_BACK: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = rbd_pkg::ST_FULL;
                     end else begin
                        count_in = CW'(count_ff + 1'b1);
                        wr_en    = 1'b1;
                        wr_addr  = slot_of(head_ff, count_lo);
                        wr_data  = req_val;
                     end
                  end
                  rbd_pkg::CMD_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = rbd_pkg::ST_EMPTY;
                     end else begin
                        head_in  = head_fwd(head_ff);
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  rbd_pkg::CMD_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = rbd_pkg::ST_EMPTY;
                     end else begin
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  rbd_pkg::CMD_GET: begin
                     if (req_idx >= count_ff) begin
                        status_in = rbd_pkg::ST_RANGE;
                     end else begin
                        get_ok_in = 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = slot_of(head_ff, idx_lo);
                     end
                  end
                  rbd_pkg::CMD_SET: begin
                     if (req_idx >= count_ff) begin
                        status_in = rbd_pkg::ST_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_of(head_ff, idx_lo);
                        wr_data = req_val;
                     end
                  end
                  rbd_pkg::CMD_INSERT: begin
                     if (req_idx > count_ff) begin
                        status_in = rbd_pkg::ST_RANGE;
                     end else if (count_ff == CW'(DEPTH)) begin
                        status_in = rbd_pkg::ST_FULL;
                     end else begin
                        count_in = CW'(count_ff + 1'b1);
                        ins_in   = 1'b1;
                        state_in = S_MOVE;
                        if (req_idx <= (count_ff >> 1)) begin
                           head_in = head_back(head_ff);
                           up_in   = 1'b1;
                           to_in   = '0;
                           left_in = req_idx;
                        end else begin
                           up_in   = 1'b0;
                           to_in   = count_lo;
                           left_in = CW'(count_ff - req_idx);
                        end
                     end
                  end
                  rbd_pkg::CMD_REMOVE: begin
                     if (req_idx >= count_ff) begin
                        status_in = rbd_pkg::ST_RANGE;
                     end else begin
                        count_in = CW'(count_ff - 1'b1);
                        state_in = S_MOVE;
                        to_in    = idx_lo;
                        if (req_idx < rem_back) begin
                           up_in    = 1'b0;
                           front_in = 1'b1;
                           left_in  = req_idx;
                        end else begin
                           up_in   = 1'b1;
                           left_in = rem_back;
                        end
                     end
                  end
                  rbd_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  rbd_pkg::CMD_RESIZE: begin
                     if (req_idx > CW'(DEPTH)) begin
                        status_in = rbd_pkg::ST_FULL;
                     end else begin
                        count_in = req_idx;
                        if (req_idx > count_ff) begin
                           state_in = S_FILL;
                           to_in    = count_lo;
                           left_in  = CW'(req_idx - count_ff);
                        end
                     end
                  end
                  rbd_pkg::CMD_SWAP: begin
                     if (req_idx >= count_ff || CW'(req_jdx) >= count_ff) begin
                        status_in = rbd_pkg::ST_RANGE;
                     end else begin
                        pos_b_in = req_jdx;
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(head_ff, idx_lo);
                        state_in = S_SWAP_A;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOVE: begin
            if (wr_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_slot_ff;
               wr_data = ram_rdata;
            end
            if (left_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(head_ff, from_pos);
               wr_pend_in = 1'b1;
               wr_slot_in = slot_of(head_ff, to_ff);
               to_in      = from_pos;
               left_in    = CW'(left_ff - 1'b1);
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  if (ins_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = slot_of(head_ff, pos_ff);
                     wr_data = val_ff;
                  end
                  if (front_ff) begin
                     head_in = head_fwd(head_ff);
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, to_ff);
            wr_data = '0;
            to_in   = AW'(to_ff + 1'b1);
            left_in = CW'(left_ff - 1'b1);
            if (left_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end
         S_SWAP_A: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, pos_b_ff);
            tmp_in   = ram_rdata;
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(head_ff, pos_ff);
            wr_data  = ram_rdata;
            state_in = S_SWAP_C;
         end
         S_SWAP_C: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(head_ff, pos_b_ff);
            wr_data  = tmp_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = get_ok_ff ? ram_rdata : '0;
               rsp_len_in    = count_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      get_ok_ff     <= get_ok_in;
      ins_ff        <= ins_in;
      front_ff      <= front_in;
      up_ff         <= up_in;
      left_ff       <= left_in;
      to_ff         <= to_in;
      pos_ff        <= pos_in;
      pos_b_ff      <= pos_b_in;
      wr_slot_ff    <= wr_slot_in;
      val_ff        <= val_in;
      tmp_ff        <= tmp_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rbd_ram #(
      .WIDTH(WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

endmodule

[rtl/core/rbd_checker.sv]
module rbd_checker #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1),
   localparam int OUT_DW = ((WIDTH + CW + 7) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [OUT_DW-1:0]         rsp_tdata,  // read_value, length
   input logic [1:0]                rsp_tuser   // status
);

   logic [WIDTH-1:0] rsp_value;
   logic [CW-1:0]    rsp_len;

   assign rsp_value = rsp_tdata[WIDTH-1:0];
   assign rsp_len   = rsp_tdata[WIDTH +: CW];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_len <= CW'(DEPTH))
      else $error("length beyond capacity");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rbd_pkg::ST_EMPTY |-> rsp_len == '0)
      else $error("empty status with nonzero length");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rbd_pkg::ST_OK |-> rsp_value == '0)
      else $error("failed command returned data");

endmodule

bind ring_buffer_deque rbd_checker #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_rbd_checker (.*);
